@@ rtl/lcgrr_pkg.sv @@
// Shared constants and controller/datapath interface types for the LCG range generator.
package lcgrr_pkg;

    localparam logic [31:0] LcgMul     = 32'd1664525;
    localparam logic [31:0] LcgAdd     = 32'd1013904223;
    localparam logic [31:0] LcgMod     = 32'hFFFF_FFFF;
    localparam logic [31:0] ErrorValue = 32'hFFFF_FFFF;

    localparam int DivSteps = 32;
    localparam int DivCntW  = $clog2(DivSteps);

    typedef struct packed {
        logic load_req;
        logic mul;
        logic add;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic bad_range;
        logic use_raw;
    } status_t;

endpackage

@@ rtl/lcgrr_ctrl.sv @@
// Controller state machine; each request runs multiply, add and division, or skips some.
module lcgrr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  lcgrr_pkg::status_t status,
    output lcgrr_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [lcgrr_pkg::DivCntW-1:0]  cnt_reg;
    logic [lcgrr_pkg::DivCntW-1:0]  cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_free;
    logic                           div_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign div_last = (cnt_reg == lcgrr_pkg::DivCntW'(lcgrr_pkg::DivSteps - 1));
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                if (status.bad_range)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add  = 1'b1;
                cnt_next = '0;
                if (status.use_raw)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The division runs its full count before the result is formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_last) |=> (state_reg == S_DIV))
        else $error("division left before its last step");

    // A request that arrives while idle is taken and starts the multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_MUL))
        else $error("idle request not taken");

    // A bad range skips the generator and goes straight to the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && status.bad_range) |=> (state_reg == S_OUT))
        else $error("bad range advanced the generator");

    // A waiting result is never dropped while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

endmodule

@@ rtl/lcgrr_dp.sv @@
// Datapath with generator state, multiply and add stages, restoring remainder unit and result register.
module lcgrr_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               kind,
    input  logic [31:0]        range_low,
    input  logic [31:0]        range_high,
    input  lcgrr_pkg::cmd_t    cmd,
    output lcgrr_pkg::status_t status,
    output logic [31:0]        random_value,
    output logic               range_error
);

    logic [31:0] state_reg;
    logic [31:0] state_next;
    logic [31:0] prod_reg;
    logic        bad_reg;
    logic        raw_reg;
    logic [31:0] low_reg;
    logic [31:0] span_reg;
    logic [31:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] value_reg;
    logic        error_reg;
    logic [31:0] span_in;
    logic [31:0] sum;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic [31:0] rem_next;

    assign span_in = range_high - range_low + 32'd1;
    assign sum     = prod_reg + lcgrr_pkg::LcgAdd;

    always_comb
    begin
        state_next = (sum == lcgrr_pkg::LcgMod) ? 32'd0 : sum;
        shifted    = {rem_reg, dvd_reg[31]};
        diff       = shifted - {1'b0, span_reg};
        rem_next   = diff[32] ? shifted[31:0] : diff[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            state_reg <= cfg_wr_data;
        end
        else if (cmd.add)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            bad_reg  <= kind && (range_low >= range_high);
            raw_reg  <= !kind || (span_in == 32'd0);
            low_reg  <= range_low;
            span_reg <= span_in;
        end
        if (cmd.mul)
        begin
            prod_reg <= state_reg * lcgrr_pkg::LcgMul;
        end
        if (cmd.add)
        begin
            dvd_reg <= state_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.load_out)
        begin
            if (bad_reg)
            begin
                value_reg <= lcgrr_pkg::ErrorValue;
                error_reg <= 1'b1;
            end
            else if (raw_reg)
            begin
                value_reg <= state_reg;
                error_reg <= 1'b0;
            end
            else
            begin
                value_reg <= rem_reg + low_reg;
                error_reg <= 1'b0;
            end
        end
    end

    assign status.bad_range = bad_reg;
    assign status.use_raw   = raw_reg;
    assign random_value     = value_reg;
    assign range_error      = error_reg;

endmodule

@@ rtl/lcg_random_range_top.sv @@
// Top level of the 32-bit LCG generator with range reduction.
// A plain or full-range request goes through the multiply and add states to its result, without the remainder unit.
// A range request also passes through the 32-step remainder unit before its result is registered.
// A bad range gives its error result without the multiply and add, so the generator does not advance.
// One request is in flight at a time; the next is taken the cycle after the result is registered.
// Reset clears the generator state, which holds the seed, to zero and drops out_valid; the result value is not reset.
module lcg_random_range_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_value,
    output logic        range_error
);

    lcgrr_pkg::cmd_t    cmd;
    lcgrr_pkg::status_t status;

    lcgrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lcgrr_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .kind         (kind),
        .range_low    (range_low),
        .range_high   (range_high),
        .cmd          (cmd),
        .status       (status),
        .random_value (random_value),
        .range_error  (range_error)
    );

endmodule
